// ===== src/hpq_pkg.sv =====
// shared types, widths and codes of the histogram percentile query block
`default_nettype none

package hpq_pkg;

  localparam int DEF_BINS      = 256;
  localparam int DEF_BANDS     = 4;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int COUNT_W       = 32;
  localparam int TOTAL_W       = 40;
  localparam int INT_W         = 16;
  localparam int SHIFT_W       = 4;
  localparam int MAX_SHIFT     = 15;
  localparam int BAND_W        = 2;
  localparam int BIN_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH_LOG2 = 2'd1;

  localparam logic [SHIFT_W-1:0] BIN_WIDTH_LOG2_RST = 4'd8;

  typedef struct packed {
    logic               mode;
    logic [BAND_W-1:0]  band;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [INT_W-1:0]   intensity;
    logic               upper_side;
  } item_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic              total_zero;
  } result_t;

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_LD_RD   = 13'b0000000000100,
    ST_LD_SUB  = 13'b0000000001000,
    ST_LD_ADD  = 13'b0000000010000,
    ST_Q_CLAMP = 13'b0000000100000,
    ST_Q_BIN   = 13'b0000001000000,
    ST_Q_SUM   = 13'b0000010000000,
    ST_Q_MUL   = 13'b0000100000000,
    ST_Q_NUM   = 13'b0001000000000,
    ST_Q_CMP   = 13'b0010000000000,
    ST_Q_DIV   = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_t;

endpackage

`default_nettype wire

// ===== src/hpq_bin_mem.sv =====
// bin count memory, one write port and one registered read port
`default_nettype none

module hpq_bin_mem #(
  parameter int  DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [hpq_pkg::COUNT_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  output logic      [hpq_pkg::COUNT_W-1:0] rd_data
);
  import hpq_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/hpq_addsub.sv =====
// shared adder and subtractor with carry out as compare result
`default_nettype none

module hpq_addsub #(
  parameter int W = 56
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] sum,
  output logic              carry
);
  import hpq_pkg::*;

  logic [W:0] full;

  // carry high on subtract means a >= b
  always_comb begin
    full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W + 1)'(sub);
    sum   = full[W-1:0];
    carry = full[W];
  end

endmodule

`default_nettype wire

// ===== src/histogram_percentile_query.sv =====
// top level: sequencer and datapath of the histogram percentile query
//
// Item channel (item_valid, item_stall, item): a load word writes one bin of one
// band and updates that band's running total, with no result. A query word
// returns one result word with the share of samples below (or above) the
// intensity, 16 fraction bits, and a flag for an empty band.
// Result channel (result_valid, result_stall, result) is fed from an output
// register, so the next word is taken while a result waits to be collected.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes range_low
// and bin_width_log2; it is always ready, and the user must see that it is
// written only while the block idles, which the block itself does not enforce.
// A load reads the bin, subtracts its old count from the band total and adds
// the new one; a load to a bin or band outside the histograms is dropped. A
// query reads the queried bin and every bin below it (lower bound) or above it
// (upper bound) with the single adder, one per cycle, then does FRACTION_BITS
// divide steps, skipped when the share saturates. An empty or absent band
// answers without walking any bin. Reset: a clearing pass writes zero to all
// BANDS*BINS bins with item_stall high; totals and config registers reset at
// once. A stalled result holds the next query in its last state until taken.
`default_nettype none

module histogram_percentile_query #(
  parameter int BINS  = hpq_pkg::DEF_BINS,
  parameter int BANDS = hpq_pkg::DEF_BANDS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire hpq_pkg::item_t                item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output hpq_pkg::result_t                   result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hpq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hpq_pkg::*;

  localparam int DEPTH   = BINS * BANDS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(BINS);
  localparam int SPAN_W  = IDX_W + 1 + MAX_SHIFT;
  localparam int SUM_W   = COUNT_W + IDX_W;
  localparam int NUM_W   = SUM_W + MAX_SHIFT + 1;
  localparam int DEN_W   = TOTAL_W + MAX_SHIFT;
  localparam int AW      = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;
  localparam int PROD_W  = COUNT_W + INT_W;
  localparam int STEP_W  = $clog2(FRACTION_BITS);

  state_t state, state_next;
  item_t  item_q;

  logic [INT_W-1:0]   range_low;
  logic [SHIFT_W-1:0] bin_width_log2;
  logic [TOTAL_W-1:0] band_totals [BANDS];
  logic [TOTAL_W-1:0] total_sel;

  logic [ADDR_W-1:0]  clr_addr, base, ld_addr, rd_addr, wr_addr;
  logic               wr_en;
  logic [COUNT_W-1:0] wr_data, rd_data;

  logic [INT_W:0]     diff;
  logic [SPAN_W-1:0]  span, off, off_next, idx_wide;
  logic               clamped;
  logic [INT_W-1:0]   w, rem, pos, pos_next;
  logic [IDX_W-1:0]   idx, idx_next, walk_b, walk_end, rd_tag;
  logic               issuing, rd_vld;
  logic [COUNT_W-1:0] count_idx;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   den;
  logic [AW-1:0]      acc, alu_a, alu_b, alu_sum;
  logic               alu_sub, alu_carry;
  logic [FRAC_W-1:0]  quo;
  logic               zflag;
  logic [STEP_W-1:0]  step;

  logic in_take, out_free, load_ok, query_empty;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign in_take    = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign load_ok     = (32'(item.band) < BANDS) && (32'(item.bin_index) < BINS);
  assign query_empty = (32'(item.band) >= BANDS) || (band_totals[item.band] == '0);

  assign total_sel = band_totals[item_q.band];
  assign base      = ADDR_W'(item_q.band) * ADDR_W'(BINS);
  assign ld_addr   = base + ADDR_W'(item_q.bin_index);
  assign rd_addr   = (state == ST_Q_SUM) ? (base + ADDR_W'(walk_b)) : ld_addr;
  assign wr_en     = (state == ST_CLEAR) || (state == ST_LD_ADD);
  assign wr_addr   = (state == ST_CLEAR) ? clr_addr : ld_addr;
  assign wr_data   = (state == ST_CLEAR) ? '0 : item_q.bin_count;

  hpq_bin_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hpq_addsub #(
    .W (AW)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // clamp and bin position
  always_comb begin
    diff     = {1'b0, item_q.intensity} - {1'b0, range_low};
    span     = SPAN_W'(BINS) << bin_width_log2;
    off_next = diff[INT_W] ? '0 :
               ((SPAN_W'(diff[INT_W-1:0]) > span) ? span : SPAN_W'(diff[INT_W-1:0]));
    idx_wide = off >> bin_width_log2;
    clamped  = (idx_wide >= SPAN_W'(BINS));
    idx_next = clamped ? IDX_W'(BINS - 1) : idx_wide[IDX_W-1:0];
    w        = INT_W'(1) << bin_width_log2;
    rem      = off[INT_W-1:0] & (w - INT_W'(1));
    if (item_q.upper_side) begin
      pos_next = clamped ? '0 : (w - rem);
    end else begin
      pos_next = clamped ? w : rem;
    end
  end

  // operand selection for the shared adder
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_LD_SUB: begin
        alu_a   = AW'(total_sel);
        alu_b   = AW'(rd_data);
        alu_sub = 1'b1;
      end
      ST_LD_ADD: begin
        alu_b = AW'(item_q.bin_count);
      end
      ST_Q_SUM: begin
        alu_b = AW'(rd_data);
      end
      ST_Q_NUM: begin
        alu_a = acc << bin_width_log2;
        alu_b = AW'(prod);
      end
      ST_Q_CMP: begin
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      ST_Q_DIV: begin
        alu_a   = acc << 1;
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) begin
          if (item.mode == MODE_LOAD) begin
            state_next = load_ok ? ST_LD_RD : ST_IDLE;
          end else begin
            state_next = query_empty ? ST_DONE : ST_Q_CLAMP;
          end
        end
      end
      ST_LD_RD:   state_next = ST_LD_SUB;
      ST_LD_SUB:  state_next = ST_LD_ADD;
      ST_LD_ADD:  state_next = ST_IDLE;
      ST_Q_CLAMP: state_next = ST_Q_BIN;
      ST_Q_BIN:   state_next = ST_Q_SUM;
      ST_Q_SUM: begin
        if (!issuing && !rd_vld) state_next = ST_Q_MUL;
      end
      ST_Q_MUL:   state_next = ST_Q_NUM;
      ST_Q_NUM:   state_next = ST_Q_CMP;
      ST_Q_CMP:   state_next = alu_carry ? ST_DONE : ST_Q_DIV;
      ST_Q_DIV: begin
        if (step == STEP_W'(FRACTION_BITS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      issuing        <= 1'b0;
      rd_vld         <= 1'b0;
      result_valid   <= 1'b0;
      range_low      <= '0;
      bin_width_log2 <= BIN_WIDTH_LOG2_RST;
      for (int i = 0; i < BANDS; i++) begin
        band_totals[i] <= '0;
      end
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_Q_SUM) && issuing;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_Q_BIN) begin
        issuing <= 1'b1;
      end else if (state == ST_Q_SUM && issuing && walk_b == walk_end) begin
        issuing <= 1'b0;
      end
      if (state == ST_LD_ADD) begin
        band_totals[item_q.band] <= alu_sum[TOTAL_W-1:0];
      end
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_LOW:      range_low      <= cfg_data[INT_W-1:0];
          REG_BIN_WIDTH_LOG2: bin_width_log2 <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q <= item;
      quo    <= '0;
      zflag  <= 1'b1;
    end
    case (state)
      ST_LD_SUB: acc <= alu_sum;
      ST_Q_CLAMP: begin
        off   <= off_next;
        zflag <= 1'b0;
      end
      ST_Q_BIN: begin
        idx      <= idx_next;
        pos      <= pos_next;
        den      <= DEN_W'(total_sel) << bin_width_log2;
        walk_b   <= item_q.upper_side ? idx_next : '0;
        walk_end <= item_q.upper_side ? IDX_W'(BINS - 1) : idx_next;
        acc      <= '0;
      end
      ST_Q_SUM: begin
        if (issuing) begin
          rd_tag <= walk_b;
          if (walk_b != walk_end) walk_b <= walk_b + IDX_W'(1);
        end
        if (rd_vld) begin
          if (rd_tag == idx) begin
            count_idx <= rd_data;
          end else begin
            acc <= alu_sum;
          end
        end
      end
      ST_Q_MUL: prod <= count_idx * pos;
      ST_Q_NUM: acc <= alu_sum;
      ST_Q_CMP: begin
        step <= '0;
        quo  <= alu_carry ? {1'b1, {FRACTION_BITS{1'b0}}} : '0;
      end
      ST_Q_DIV: begin
        acc  <= alu_carry ? alu_sum : (acc << 1);
        quo  <= {quo[FRAC_W-2:0], alu_carry};
        step <= step + STEP_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          result.fraction   <= quo;
          result.total_zero <= zflag;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/hpq_checker.sv =====
// checker for the histogram percentile query: tracks the histograms, predicts and compares
`timescale 1ns / 100ps

module hpq_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  hpq_pkg::item_t                 item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  hpq_pkg::result_t               result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             errors
);
  import hpq_pkg::*;

  logic [COUNT_W-1:0] hist_bins [0:DEF_BANDS*DEF_BINS-1];
  logic [TOTAL_W-1:0] hist_totals [0:DEF_BANDS-1];
  logic [INT_W-1:0]   lo_edge;
  logic [SHIFT_W-1:0] width_log2;
  result_t            awaited_shares [$];

  function automatic result_t answer_query(input item_t w);
    logic [63:0] span, hi, x, bin, lo_bin, pos, others, num, den, quot, rem;
    int base;
    result_t a;
    a = '0;
    if (int'(w.band) >= DEF_BANDS || hist_totals[w.band] == '0) begin
      a.total_zero = 1'b1;
      return a;
    end
    base = int'(w.band) * DEF_BINS;
    span = 64'd1 << width_log2;
    hi = 64'(lo_edge) + (64'(DEF_BINS) << width_log2);
    if (w.intensity < lo_edge) begin
      x = 64'(lo_edge);
    end else if (64'(w.intensity) > hi) begin
      x = hi;
    end else begin
      x = 64'(w.intensity);
    end
    bin = (x - 64'(lo_edge)) >> width_log2;
    if (bin >= DEF_BINS) begin
      bin = 64'(DEF_BINS - 1);
    end
    lo_bin = 64'(lo_edge) + (bin << width_log2);
    pos = w.upper_side ? (lo_bin + span - x) : (x - lo_bin);
    others = '0;
    for (int b = 0; b < DEF_BINS; b++) begin
      if (w.upper_side ? (64'(b) > bin) : (64'(b) < bin)) begin
        others += 64'(hist_bins[base + b]);
      end
    end
    num = (others << width_log2) + 64'(hist_bins[base + int'(bin)]) * pos;
    den = 64'(hist_totals[w.band]) << width_log2;
    if (num >= den) begin
      quot = 64'd1 << FRACTION_BITS;
    end else begin
      quot = '0;
      rem = num;
      repeat (FRACTION_BITS) begin
        rem = rem << 1;
        quot = quot << 1;
        if (rem >= den) begin
          rem = rem - den;
          quot[0] = 1'b1;
        end
      end
    end
    a.fraction = quot[FRAC_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    int slot;
    result_t exp_word;
    if (rst) begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      foreach (hist_totals[i]) hist_totals[i] = '0;
      lo_edge = '0;
      width_log2 = BIN_WIDTH_LOG2_RST;
      awaited_shares.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_LOW: begin
            lo_edge = cfg_data[INT_W-1:0];
          end
          REG_BIN_WIDTH_LOG2: begin
            width_log2 = cfg_data[SHIFT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (awaited_shares.size() == 0) begin
          errors++;
          $error("result word with no query outstanding: fraction %0d total_zero %0d",
                 result.fraction, result.total_zero);
        end else begin
          exp_word = awaited_shares.pop_front();
          if (result.fraction !== exp_word.fraction) begin
            errors++;
            $error("fraction: expected %0d, got %0d", exp_word.fraction, result.fraction);
          end
          if (result.total_zero !== exp_word.total_zero) begin
            errors++;
            $error("total_zero: expected %0d, got %0d", exp_word.total_zero,
                   result.total_zero);
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.mode == MODE_QUERY) begin
          awaited_shares.push_back(answer_query(item));
        end else if (int'(item.band) < DEF_BANDS && int'(item.bin_index) < DEF_BINS) begin
          slot = int'(item.band) * DEF_BINS + int'(item.bin_index);
          hist_totals[item.band] = hist_totals[item.band] - TOTAL_W'(hist_bins[slot])
                                   + TOTAL_W'(item.bin_count);
          hist_bins[slot] = item.bin_count;
        end
      end
      pending = awaited_shares.size();
    end
  end

endmodule

// ===== tb/sv/tb_histogram_percentile_query.sv =====
// testbench top for the histogram percentile query: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_histogram_percentile_query;
  import hpq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    awaiting;
  int                    fail_count;
  int                    cur_lo = 0;
  int                    cur_shift = int'(BIN_WIDTH_LOG2_RST);
  int                    stall_mode = 0;
  int                    stall_left = 0;

  histogram_percentile_query dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  hpq_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (awaiting),
    .errors       (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        result_stall <= 1'b0;
      end
      1: begin
        result_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        result_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  function automatic item_t mk_word(input logic mode, input int band, input int bin,
                                    input logic [COUNT_W-1:0] count, input int inten,
                                    input logic upper);
    item_t w;
    w.mode = mode;
    w.band = band[BAND_W-1:0];
    w.bin_index = bin[BIN_W-1:0];
    w.bin_count = count;
    w.intensity = inten[INT_W-1:0];
    w.upper_side = upper;
    return w;
  endfunction

  task automatic drive_word(input item_t w);
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    item_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] shift_word, input bit stray);
    cfg_word(REG_RANGE_LOW, lo);
    cfg_word(REG_BIN_WIDTH_LOG2, shift_word);
    if (stray) begin
      cfg_word(REG_SPARE_A, CFG_DATA_W'($urandom));
      cfg_word(REG_SPARE_B, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    cur_lo = int'(lo);
    cur_shift = int'(shift_word[SHIFT_W-1:0]);
  endtask

  task automatic run_random(input int count);
    item_t w;
    int k, burst, span_top, pick;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && k < count) begin
        w.mode = ($urandom_range(0, 99) < 45) ? MODE_LOAD : MODE_QUERY;
        w.band = BAND_W'($urandom);
        w.bin_index = BIN_W'($urandom);
        w.upper_side = 1'($urandom);
        pick = $urandom_range(0, 4);
        case (pick)
          0, 1: w.bin_count = $urandom;
          2: w.bin_count = $urandom_range(0, 1000);
          3: w.bin_count = '0;
          default: w.bin_count = '1;
        endcase
        span_top = cur_lo + (DEF_BINS << cur_shift);
        if (span_top > 65535) begin
          span_top = 65535;
        end
        if ($urandom_range(0, 9) < 7) begin
          w.intensity = INT_W'($urandom_range(cur_lo, span_top));
        end else begin
          w.intensity = INT_W'($urandom);
        end
        drive_word(w);
        k++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty bands first, then a sparse band 0 probed at both ends
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 0, 1'b0));
    drive_word(mk_word(MODE_QUERY, 3, 0, '0, 65535, 1'b1));
    drive_word(mk_word(MODE_LOAD, 0, 0, '1, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 0, 255, 32'd1, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 0, 128, 32'd1000, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 1, 17, 32'd5, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 2, 0, '0, 0, 1'b0));
    idle_cycles(3);
    drive_word(mk_word(MODE_QUERY, 2, 0, '0, 100, 1'b0));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 0, 1'b0));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 0, 1'b1));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 65535, 1'b0));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 65535, 1'b1));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 32868, 1'b0));
    drive_word(mk_word(MODE_QUERY, 1, 0, '0, 17 * 256 + 255, 1'b1));
    drive_word(mk_word(MODE_QUERY, 1, 0, '0, 17 * 256, 1'b0));
    // overwrite shrinks the running total
    drive_word(mk_word(MODE_LOAD, 0, 0, '0, 0, 1'b0));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 32768, 1'b0));
    drive_word(mk_word(MODE_QUERY, 0, 0, '0, 32768, 1'b1));
    drive_word(mk_word(MODE_LOAD, 3, 255, '1, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 3, 254, '1, 0, 1'b0));
    drive_word(mk_word(MODE_LOAD, 3, 0, 32'h8000_0000, 0, 1'b0));
    drive_word(mk_word(MODE_QUERY, 3, 0, '0, 65535, 1'b0));
    drive_word(mk_word(MODE_QUERY, 3, 0, '0, 65280, 1'b1));
    settle();

    run_random(60);
    settle();
    apply_setting(16'h0000, 16'h0000, 1'b0);
    run_random(70);
    settle();
    apply_setting(16'hFFFF, 16'h000F, 1'b0);
    run_random(60);
    settle();
    apply_setting(16'd1000, 16'hFFF4, 1'b1);
    run_random(70);
    settle();
    apply_setting(16'd30000, 16'h0009, 1'b0);
    run_random(60);
    settle();
    apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
    run_random(70);
    settle();

    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/hpq_pkg.sv
src/hpq_bin_mem.sv
src/hpq_addsub.sv
src/histogram_percentile_query.sv
tb/sv/hpq_checker.sv
tb/sv/tb_histogram_percentile_query.sv
